// ===== rtl/core/time_weighted_history_ring_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the time weighted history ring
// Shared property forms used by the RTL assertions.
// ----------------------------------------------------------------------------
`ifndef TIME_WEIGHTED_HISTORY_RING_UNIT_DEFINES_SVH
`define TIME_WEIGHTED_HISTORY_RING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TWHR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twhr assertion failed");

// Next-cycle implication, disabled during reset.
`define TWHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twhr assertion failed");

`endif

// ===== rtl/core/twhr_pkg.sv =====
// ----------------------------------------------------------------------------
// twhr_pkg
// Types and constants for the time weighted history ring.
// ----------------------------------------------------------------------------
package twhr_pkg;

  localparam int DEFAULT_RING_DEPTH = 16;
  localparam int QUO_BITS = 17;

  localparam logic [15:0] Q_POS_MAX = 16'h7fff;
  localparam logic [15:0] Q_NEG_MIN = 16'h8000;

  typedef struct packed {
    logic [31:0] span;
    logic [31:0] last_tick;
    logic [15:0] hgt;
    logic [15:0] yaw;
    logic [15:0] vy;
    logic [15:0] vx;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN,
    ST_WRITE
  } state_t;

endpackage

// ===== rtl/core/time_weighted_history_ring_unit.sv =====
// A sample that opens a new slot (empty ring or start flag set) goes straight
// to the slot write; one that lands on a slot with zero span takes a slot
// read and then the slot write. A merge reads the slot, then the one 33x16
// multiplier and the one-bit-a-cycle divider compute the three averages in
// turn, and the slot is written. The ring memory has one registered read port
// and one write port. The input is not ready while an item is at work, and a
// finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
// time_weighted_history_ring_unit
// Ring of motion-history slots with time-weighted merging of samples.
// ----------------------------------------------------------------------------
`include "time_weighted_history_ring_unit_defines.svh"

module time_weighted_history_ring_unit #(
  parameter int RING_DEPTH = twhr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stamp_tick, sample_span, vel_x, vel_y, yaw_rate, height
  input  logic [111:0] s_axis_tdata,
  // start_new
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_index, avg_vel_x, avg_vel_y, avg_yaw_rate, slot_height,
  // slot_last_tick, slot_span, fill_count, ring_full, zero fill
  output logic [143:0] m_axis_tdata
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int QB = twhr_pkg::QUO_BITS;

  twhr_pkg::state_t state, state_next;

  twhr_pkg::slot_t mem [RING_DEPTH];
  twhr_pkg::slot_t rd_q;
  twhr_pkg::slot_t wslot;

  logic [AW-1:0] write_pointer;
  logic [AW-1:0] current_slot;
  logic [CW-1:0] valid_count;
  logic [AW-1:0] w_idx;
  logic          is_new;

  logic [31:0]        in_stamp;
  logic [15:0]        in_hgt;
  logic signed [15:0] new_val [0:2];
  logic signed [15:0] old_val [0:2];
  logic [15:0]        w_val   [0:2];
  logic [1:0]         chan;

  logic [31:0] span_q;
  logic [31:0] gap_q;
  logic [31:0] total_q;
  logic [31:0] rd_gap;
  logic [32:0] rd_sum;

  logic signed [32:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [48:0] prod;
  logic signed [48:0] prod_q;
  logic signed [49:0] num_q;
  logic [49:0]        mag;

  logic [31:0]    rem;
  logic [QB-1:0]  low;
  logic [QB-1:0]  quo;
  logic [4:0]     cnt;
  logic           ovf;
  logic           neg;
  logic [32:0]    rem2;
  logic           ge;
  logic [32:0]    rem_sub;
  logic [QB-1:0]  quo_neg;
  logic [15:0]    sat_val;

  logic          in_take;
  logic          rd_zero;
  logic          wr_go;
  logic [CW-1:0] count_next;
  logic [AW+3:0] idx_wide;
  logic [CW+4:0] cnt_wide;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      twhr_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = ((valid_count == '0) || s_axis_tuser) ? twhr_pkg::ST_WRITE
                                                             : twhr_pkg::ST_READ;
        end
      end
      twhr_pkg::ST_READ: begin
        state_next = rd_zero ? twhr_pkg::ST_WRITE : twhr_pkg::ST_MUL_A;
      end
      twhr_pkg::ST_MUL_A:    state_next = twhr_pkg::ST_MUL_B;
      twhr_pkg::ST_MUL_B:    state_next = twhr_pkg::ST_DIV_INIT;
      twhr_pkg::ST_DIV_INIT: state_next = twhr_pkg::ST_DIV;
      twhr_pkg::ST_DIV: begin
        if (cnt == 5'(QB - 1)) begin
          state_next = twhr_pkg::ST_FIN;
        end
      end
      twhr_pkg::ST_FIN: begin
        state_next = (chan == 2'd2) ? twhr_pkg::ST_WRITE : twhr_pkg::ST_MUL_A;
      end
      twhr_pkg::ST_WRITE: begin
        if (wr_go) begin
          state_next = twhr_pkg::ST_IDLE;
        end
      end
      default: state_next = twhr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = (state == twhr_pkg::ST_IDLE);
    in_take       = s_axis_tvalid && (state == twhr_pkg::ST_IDLE);
    wr_go         = (state == twhr_pkg::ST_WRITE) && (!m_axis_tvalid || m_axis_tready);
  end

  // Shared multiplier, gap and span total.
  always_comb begin
    if (state == twhr_pkg::ST_MUL_A) begin
      mul_a = {1'b0, span_q};
      mul_b = old_val[chan];
    end else begin
      mul_a = {1'b0, gap_q};
      mul_b = new_val[chan];
    end
    prod    = mul_a * mul_b;
    rd_zero = (rd_q.span == '0);
    rd_gap  = in_stamp - rd_q.last_tick;
    rd_sum  = {1'b0, rd_q.span} + {1'b0, rd_gap};
    mag     = num_q[49] ? (~num_q + 50'd1) : num_q;
  end

  // Divider step and saturation.
  always_comb begin
    rem2    = {rem, low[QB-1]};
    ge      = (rem2 >= {1'b0, total_q});
    rem_sub = rem2 - {1'b0, total_q};
    quo_neg = ~quo + QB'(1);
    if (ovf) begin
      sat_val = neg ? twhr_pkg::Q_NEG_MIN : twhr_pkg::Q_POS_MAX;
    end else if (!neg) begin
      sat_val = (quo > QB'(32767)) ? twhr_pkg::Q_POS_MAX : quo[15:0];
    end else begin
      sat_val = (quo > QB'(32768)) ? twhr_pkg::Q_NEG_MIN : quo_neg[15:0];
    end
  end

  // Slot to write and ring bookkeeping.
  always_comb begin
    wslot.vx        = w_val[0];
    wslot.vy        = w_val[1];
    wslot.yaw       = w_val[2];
    wslot.hgt       = in_hgt;
    wslot.last_tick = in_stamp;
    wslot.span      = total_q;
    if (is_new && (valid_count < CW'(RING_DEPTH))) begin
      count_next = valid_count + CW'(1);
    end else begin
      count_next = valid_count;
    end
    idx_wide = {4'b0, w_idx};
    cnt_wide = {5'b0, count_next};
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[current_slot];
    if (wr_go) begin
      mem[w_idx] <= wslot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= twhr_pkg::ST_IDLE;
      write_pointer <= '0;
      current_slot  <= '0;
      valid_count   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_go) begin
        m_axis_tvalid <= 1'b1;
        valid_count   <= count_next;
        current_slot  <= w_idx;
        if (is_new) begin
          write_pointer <= (write_pointer == AW'(RING_DEPTH - 1)) ? '0
                                                                  : write_pointer + AW'(1);
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_stamp   <= s_axis_tdata[31:0];
      new_val[0] <= s_axis_tdata[63:48];
      new_val[1] <= s_axis_tdata[79:64];
      new_val[2] <= s_axis_tdata[95:80];
      in_hgt     <= s_axis_tdata[111:96];
      w_val[0]   <= s_axis_tdata[63:48];
      w_val[1]   <= s_axis_tdata[79:64];
      w_val[2]   <= s_axis_tdata[95:80];
      total_q    <= {16'b0, s_axis_tdata[47:32]};
      is_new     <= (valid_count == '0) || s_axis_tuser;
      w_idx      <= ((valid_count == '0) || s_axis_tuser) ? write_pointer : current_slot;
    end
    unique case (state)
      twhr_pkg::ST_READ: begin
        span_q     <= rd_q.span;
        gap_q      <= rd_gap;
        old_val[0] <= rd_q.vx;
        old_val[1] <= rd_q.vy;
        old_val[2] <= rd_q.yaw;
        chan       <= 2'd0;
        if (!rd_zero) begin
          total_q <= rd_sum[32] ? 32'hffff_ffff : rd_sum[31:0];
        end
      end
      twhr_pkg::ST_MUL_A: begin
        prod_q <= prod;
      end
      twhr_pkg::ST_MUL_B: begin
        num_q <= {prod_q[48], prod_q} + {prod[48], prod};
      end
      twhr_pkg::ST_DIV_INIT: begin
        neg <= num_q[49];
        ovf <= (mag[49:QB] >= {1'b0, total_q});
        rem <= mag[QB+31:QB];
        low <= mag[QB-1:0];
        quo <= '0;
        cnt <= '0;
      end
      twhr_pkg::ST_DIV: begin
        rem <= ge ? rem_sub[31:0] : rem2[31:0];
        low <= {low[QB-2:0], 1'b0};
        quo <= {quo[QB-2:0], ge};
        cnt <= cnt + 5'd1;
      end
      twhr_pkg::ST_FIN: begin
        w_val[chan] <= sat_val;
        chan        <= chan + 2'd1;
      end
      default: begin
      end
    endcase
    if (wr_go) begin
      m_axis_tdata <= {6'b0, (count_next == CW'(RING_DEPTH)), cnt_wide[4:0],
                       wslot.span, wslot.last_tick, wslot.hgt,
                       wslot.yaw, wslot.vy, wslot.vx, idx_wide[3:0]};
    end
  end

  `TWHR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, valid_count <= CW'(RING_DEPTH))
  `TWHR_ASSERT_NOW(a_wp_bound, clk, rst, 1'b1, write_pointer <= AW'(RING_DEPTH - 1))
  `TWHR_ASSERT_NOW(a_rem_bound, clk, rst, (state == twhr_pkg::ST_DIV) && !ovf, rem < total_q)
  `TWHR_ASSERT_NEXT(a_result_src, clk, rst, !m_axis_tvalid && !wr_go, !m_axis_tvalid)
  `TWHR_ASSERT_NOW(a_chan_bound, clk, rst, state == twhr_pkg::ST_FIN, chan <= 2'd2)

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for time_weighted_history_ring_unit
// Drives motion samples over the input stream and predicts every slot update.
// Slot opens, zero-span copies and time-weighted merges are covered, including
// wrapped tick gaps and saturated spans. Results are checked field by field,
// in order, while both stream sides idle at random before a final quiet run.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS = twhr_pkg::DEFAULT_RING_DEPTH;
  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_ITEMS = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic signed [15:0] hgt;
    logic [31:0]        tick;
    logic [31:0]        span;
  } history_slot_t;

  typedef struct {
    logic [3:0]  slot_idx;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] yaw;
    logic [15:0] hgt;
    logic [31:0] tick;
    logic [31:0] span;
    logic [4:0]  fill;
    logic        full;
  } slot_report_t;

  class ring_scoreboard;
    history_slot_t slots[RING_SLOTS];
    int unsigned   wr_ptr;
    int unsigned   cur_slot;
    int unsigned   valid_cnt;
    slot_report_t  expected_slots[$];
    int            errors;
    int            opens;
    int            merges;
    int            copies;
    int            saturated_spans;

    function new();
      wr_ptr = 0;
      cur_slot = 0;
      valid_cnt = 0;
      errors = 0;
      opens = 0;
      merges = 0;
      copies = 0;
      saturated_spans = 0;
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    function logic signed [15:0] blend(logic [31:0] span, logic signed [15:0] old_v,
                                       logic [31:0] gap, logic signed [15:0] new_v,
                                       logic [31:0] total);
      longint num;
      longint quo;
      num = longint'(span) * longint'(old_v) + longint'(gap) * longint'(new_v);
      quo = num / longint'(total);
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      return quo[15:0];
    endfunction

    function void note_sample(bit start_new, logic [111:0] data);
      history_slot_t fresh;
      history_slot_t cur;
      logic [31:0]   gap;
      logic [32:0]   sum;
      logic [31:0]   total;
      slot_report_t  rep;
      fresh.tick = data[31:0];
      fresh.span = {16'b0, data[47:32]};
      fresh.vx = data[63:48];
      fresh.vy = data[79:64];
      fresh.yaw = data[95:80];
      fresh.hgt = data[111:96];
      if (valid_cnt == 0 || start_new) begin
        if (valid_cnt < RING_SLOTS) valid_cnt++;
        slots[wr_ptr] = fresh;
        cur_slot = wr_ptr;
        wr_ptr = (wr_ptr + 1 >= RING_SLOTS) ? 0 : wr_ptr + 1;
        opens++;
      end else if (slots[cur_slot].span == 0) begin
        slots[cur_slot] = fresh;
        copies++;
      end else begin
        cur = slots[cur_slot];
        gap = fresh.tick - cur.tick;
        sum = {1'b0, cur.span} + {1'b0, gap};
        total = sum[32] ? 32'hffff_ffff : sum[31:0];
        if (sum[32]) saturated_spans++;
        cur.vx = blend(cur.span, cur.vx, gap, fresh.vx, total);
        cur.vy = blend(cur.span, cur.vy, gap, fresh.vy, total);
        cur.yaw = blend(cur.span, cur.yaw, gap, fresh.yaw, total);
        cur.hgt = fresh.hgt;
        cur.tick = fresh.tick;
        cur.span = total;
        slots[cur_slot] = cur;
        merges++;
      end
      cur = slots[cur_slot];
      rep.slot_idx = cur_slot[3:0];
      rep.vx = cur.vx;
      rep.vy = cur.vy;
      rep.yaw = cur.yaw;
      rep.hgt = cur.hgt;
      rep.tick = cur.tick;
      rep.span = cur.span;
      rep.fill = valid_cnt[4:0];
      rep.full = (valid_cnt == RING_SLOTS);
      expected_slots.push_back(rep);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_slot(logic [143:0] word);
      slot_report_t want;
      if (expected_slots.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h",
                 $time, word);
        errors++;
        return;
      end
      want = expected_slots.pop_front();
      compare("slot_index", 32'(want.slot_idx), 32'(word[3:0]));
      compare("avg_vel_x", 32'(want.vx), 32'(word[19:4]));
      compare("avg_vel_y", 32'(want.vy), 32'(word[35:20]));
      compare("avg_yaw_rate", 32'(want.yaw), 32'(word[51:36]));
      compare("slot_height", 32'(want.hgt), 32'(word[67:52]));
      compare("slot_last_tick", want.tick, word[99:68]);
      compare("slot_span", want.span, word[131:100]);
      compare("fill_count", 32'(want.fill), 32'(word[136:132]));
      compare("ring_full", 32'(want.full), 32'(word[137]));
      compare("zero fill", 32'd0, 32'(word[143:138]));
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  ring_scoreboard sb = new();
  bit             quiet = 1'b0;
  int             stall_cycles = 0;
  logic [31:0]    last_stamp = '0;

  time_weighted_history_ring_unit uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_sample(input bit start_new, input logic [31:0] stamp,
                             input logic [15:0] span, input logic [15:0] vx,
                             input logic [15:0] vy, input logic [15:0] yaw,
                             input logic [15:0] hgt);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= start_new;
    s_axis_tdata <= {hgt, yaw, vy, vx, span, stamp};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(start_new, {hgt, yaw, vy, vx, span, stamp});
    last_stamp = stamp;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_slot(m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    bit          start_new;
    logic [31:0] stamp;
    logic [15:0] span;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser <= 1'b0;
    s_axis_tdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An empty ring opens a slot even without the start flag.
    send_sample(1'b0, 32'd1000, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(1'b0, 32'd1100, 16'd200, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_sample(1'b0, 32'd1300, 16'd7, 16'h8000, 16'h7fff, 16'hffff, 16'h7fff);
    send_sample(1'b0, 32'd1300, 16'd9, 16'h1234, 16'h8765, 16'h0100, 16'h8000);
    send_sample(1'b1, 32'd0, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(1'b0, 32'hffff_ffff, 16'd3, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    // Build a span past 2^31, then a wrapped gap saturates span and averages.
    send_sample(1'b1, 32'd0, 16'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
    send_sample(1'b0, 32'h8000_0000, 16'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001);
    send_sample(1'b0, 32'h7fff_ffff, 16'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'h0002);
    send_sample(1'b1, 32'd5000, 16'd10, 16'h0100, 16'hff00, 16'h0080, 16'h0200);
    send_sample(1'b0, 32'd4990, 16'd10, 16'hff00, 16'h0100, 16'hff80, 16'h0300);
    send_sample(1'b1, 32'd6000, 16'd0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_sample(1'b1, 32'd6100, 16'd0, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_sample(1'b0, 32'd6200, 16'hffff, 16'h0001, 16'hfffe, 16'h0003, 16'hfffc);
    send_sample(1'b0, 32'd6201, 16'd0, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (i % 450 == 449) hold_until_drained();
      start_new = ($urandom_range(0, 9) < 3);
      case ($urandom_range(0, 19))
        0: stamp = $urandom();
        1: stamp = last_stamp - $urandom_range(1, 1000);
        2: stamp = last_stamp;
        3: stamp = last_stamp + 32'h8000_0000 + $urandom_range(0, 65535);
        default: stamp = last_stamp + $urandom_range(1, 5000);
      endcase
      case ($urandom_range(0, 9))
        0: span = 16'd0;
        1: span = 16'hffff;
        default: span = 16'($urandom());
      endcase
      send_sample(start_new, stamp, span, pick_value(), pick_value(), pick_value(),
                  pick_value());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d slot opens, %0d weighted merges, %0d zero-span copies,",
             sb.opens, sb.merges, sb.copies);
    $display("%0d merges with a saturated span, under random stalls on both sides.",
             sb.saturated_spans);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== time_weighted_history_ring_unit.f =====
+incdir+rtl/core
rtl/core/twhr_pkg.sv
rtl/core/time_weighted_history_ring_unit.sv
dv/testbench.sv
